>>> rtl/core/tcw_pkg.sv
// Shared constants, types and address helpers for the text console writer.
package tcw_pkg;

	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = CHAR_W + ATTR_W;
	localparam int ROW_FIELD_W = 5;
	localparam int COL_FIELD_W = 7;

	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int COL_W  = $clog2(SCREEN_COLS + 1);
	localparam int ADDR_W = $clog2(CELL_COUNT);

	localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic [CHAR_W-1:0]      cell_char;
		logic [ATTR_W-1:0]      cell_attr;
		logic [ROW_FIELD_W-1:0] cursor_row;
		logic [COL_FIELD_W-1:0] cursor_col;
	} res_t;

	// screen row -> storage row, rotated by the top-row pointer
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
	                                              input logic [ROW_W-1:0] top);
		logic [ROW_W:0] sum;
		sum = {1'b0, lrow} + {1'b0, top};
		if (sum >= (ROW_W+1)'(SCREEN_ROWS))
			sum = sum - (ROW_W+1)'(SCREEN_ROWS);
		return sum[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
	                                                input logic [COL_W-1:0] col);
		return ADDR_W'(prow) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
	endfunction

endpackage

>>> rtl/core/tcw_ifs.sv
// Channel interfaces: put/read requests, results and the attribute register write.
interface tcw_req_if import tcw_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [CHAR_W-1:0]      char_code;
	logic [ROW_FIELD_W-1:0] read_row;
	logic [COL_FIELD_W-1:0] read_col;

	modport source (output valid, op, char_code, read_row, read_col, input ready);
	modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CHAR_W-1:0]      cell_char;
	logic [ATTR_W-1:0]      cell_attr;
	logic [ROW_FIELD_W-1:0] cursor_row;
	logic [COL_FIELD_W-1:0] cursor_col;

	modport source (output valid, cell_char, cell_attr, cursor_row, cursor_col, input ready);
	modport sink   (input valid, cell_char, cell_attr, cursor_row, cursor_col, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] text_attribute;

	modport source (output valid, text_attribute, input ready);
	modport sink   (input valid, text_attribute, output ready);
endinterface

>>> rtl/core/tcw_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	assign rd = rd_q;

endmodule

>>> rtl/core/tcw_ctrl.sv
// Cursor, scroll pointer and screen-store sequencer of the text console writer.
module tcw_ctrl import tcw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	tcw_req_if.sink      req,
	tcw_cfg_if.sink      cfg,
	output logic         res_valid,
	output res_t         res,
	input  logic         res_take
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_BLANK = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  top_q;
	logic [ATTR_W-1:0] attr_q;
	logic [COL_W-1:0]  blank_col_q;
	logic [ADDR_W-1:0] blank_base_q;
	logic              rd_ok_q;
	res_t              res_q;

	logic              acc;
	logic              is_nl;
	logic              wrap;
	logic              scroll;
	logic [COL_W-1:0]  col_inc;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;
	logic [ROW_W-1:0]  nxt_top;
	logic [ADDR_W-1:0] put_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_in_range;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_wa;
	logic [CELL_W-1:0] ram_wd;
	logic [CELL_W-1:0] ram_rd;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign acc       = req.valid && req.ready;
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	always_comb begin
		col_inc     = col_q + COL_W'(1);
		is_nl       = (req.char_code == NEWLINE_CHAR);
		wrap        = is_nl || (col_inc == COL_W'(SCREEN_COLS));
		scroll      = wrap && (row_q == LAST_ROW);
		nxt_col     = wrap ? '0 : col_inc;
		nxt_row     = (wrap && !scroll) ? row_q + ROW_W'(1) : row_q;
		nxt_top     = (top_q == LAST_ROW) ? '0 : top_q + ROW_W'(1);
		put_addr    = cell_addr(phys_row(row_q, top_q), col_q);
		rd_addr     = cell_addr(phys_row(ROW_W'(req.read_row), top_q), COL_W'(req.read_col));
		rd_in_range = (32'(req.read_row) < SCREEN_ROWS) && (32'(req.read_col) < SCREEN_COLS);
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = put_addr;
		ram_wd = {attr_q, req.char_code};
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_addr_q;
				ram_wd = {RESET_ATTR, BLANK_CHAR};
			end
			ST_IDLE: begin
				ram_we = acc && (req.op == OP_PUT) && !is_nl;
			end
			ST_BLANK: begin
				ram_we = 1'b1;
				ram_wa = blank_base_q + ADDR_W'(blank_col_q);
				ram_wd = {attr_q, BLANK_CHAR};
			end
			default: ;
		endcase
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk(clk),
		.we (ram_we),
		.wa (ram_wa),
		.wd (ram_wd),
		.ra (rd_addr),
		.rd (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			top_q       <= '0;
			attr_q      <= RESET_ATTR;
			blank_col_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready)
				attr_q <= cfg.text_attribute;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(CELL_COUNT - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc) begin
						if (req.op == OP_READ) begin
							state_q <= ST_READ;
						end else begin
							col_q <= nxt_col;
							row_q <= nxt_row;
							if (scroll) begin
								top_q       <= nxt_top;
								blank_col_q <= '0;
								state_q     <= ST_BLANK;
							end else begin
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_BLANK: begin
					blank_col_q <= blank_col_q + COL_W'(1);
					if (blank_col_q == COL_W'(SCREEN_COLS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc) begin
			if (req.op == OP_READ) begin
				rd_ok_q <= rd_in_range;
			end else begin
				res_q.cell_char  <= is_nl ? '0 : req.char_code;
				res_q.cell_attr  <= is_nl ? '0 : attr_q;
				res_q.cursor_row <= ROW_FIELD_W'(nxt_row);
				res_q.cursor_col <= COL_FIELD_W'(nxt_col);
				// old top row becomes the new bottom row
				if (scroll)
					blank_base_q <= cell_addr(top_q, '0);
			end
		end
		if (state_q == ST_READ) begin
			res_q.cell_char  <= rd_ok_q ? ram_rd[CHAR_W-1:0] : '0;
			res_q.cell_attr  <= rd_ok_q ? ram_rd[CELL_W-1:CHAR_W] : '0;
			res_q.cursor_row <= ROW_FIELD_W'(row_q);
			res_q.cursor_col <= COL_FIELD_W'(col_q);
		end
	end

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < SCREEN_ROWS) && (32'(col_q) < SCREEN_COLS) && (32'(top_q) < SCREEN_ROWS))
		else $error("cursor or top-row pointer out of range");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_DONE) |-> !ram_we)
		else $error("screen write outside put, clear or blank");

	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.op == OP_READ) |=> (state_q == ST_READ) ##1 (state_q == ST_DONE))
		else $error("read transaction did not complete in two cycles");

	a_scroll_top: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.op == OP_PUT && scroll) |=> (row_q == LAST_ROW) && (col_q == '0)
		&& (top_q != $past(top_q)))
		else $error("scroll did not rotate the top-row pointer");

	a_blank_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLANK) |-> (32'(blank_col_q) < SCREEN_COLS))
		else $error("blank sweep past last column");

endmodule

>>> rtl/core/text_console_writer.sv
// Text console writer top level: sequencer plus result output register.
// Text console of 80 x 25 cells held in one 2000 x 16 RAM (attribute in the upper
// byte, character in the lower). After reset a clearing pass writes a space with
// attribute 0x0F to all 2000 cells, one per cycle, and no request is taken until
// the pass ends; attribute writes are taken at any time. A drawn character or
// newline result is held in the sequencer, then in the output register; a read
// first passes the registered RAM read. Scrolling rotates a top-row pointer instead
// of copying rows, so a put that scrolls adds one RAM write per cell to blank the
// new bottom row. One request is in flight at a time; a result waiting in the
// output register does not hold off the next request.
module text_console_writer import tcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tcw_req_if.sink   req,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);

	logic res_valid;
	res_t res;
	logic res_take;
	logic out_valid_q;
	res_t rsp_q;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.res_valid(res_valid),
		.res      (res),
		.res_take (res_take)
	);

	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take)
			rsp_q <= res;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cell_char  = rsp_q.cell_char;
	assign rsp.cell_attr  = rsp_q.cell_attr;
	assign rsp.cursor_row = rsp_q.cursor_row;
	assign rsp.cursor_col = rsp_q.cursor_col;

endmodule
